FILE: hdl/gcbw_pkg.sv
// gcbw_pkg: shared constants for the glyph coverage blend writer.
// Used by gcbw_blend and glyph_coverage_blend_writer_top; no dependencies.
`timescale 1ns / 1ps

package gcbw_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int PITCH_W   = 15;
    localparam int OFF_W     = 26;
    localparam int CH_W      = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    localparam logic [CH_W-1:0]  CH_MAX      = 8'd255;
    localparam logic [15:0]      BLEND_ROUND = 16'h0080;

    localparam logic [DIM_W-1:0]   RST_SCREEN_W = 13'd1024;
    localparam logic [DIM_W-1:0]   RST_SCREEN_H = 13'd768;
    localparam logic [PITCH_W-1:0] RST_PITCH    = 15'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH     = 2'd2;

    localparam logic [1:0] STATUS_WRITTEN    = 2'd0;
    localparam logic [1:0] STATUS_CLIPPED    = 2'd1;
    localparam logic [1:0] STATUS_ORIGIN_ERR = 2'd2;

endpackage

FILE: hdl/gcbw_blend.sv
// gcbw_blend: one colour channel of the coverage blend, divide by 255 approximated.
// Depends on gcbw_pkg.
`timescale 1ns / 1ps

module gcbw_blend import gcbw_pkg::*; (
    input  logic [CH_W-1:0] i_fore,
    input  logic [CH_W-1:0] i_back,
    input  logic [CH_W-1:0] i_cov,
    output logic [CH_W-1:0] o_chan
);

    logic [15:0] w_fore_prod;
    logic [15:0] w_back_prod;
    logic [15:0] w_sum;
    logic [15:0] w_fold;

    always_comb begin
        w_fore_prod = 16'(i_fore) * 16'(i_cov);
        w_back_prod = 16'(i_back) * 16'(CH_MAX - i_cov);
        w_sum       = w_fore_prod + w_back_prod + BLEND_ROUND;
        w_fold      = w_sum + {8'd0, w_sum[15:8]};
        if (i_cov == '0) begin
            o_chan = i_back;
        end else if (i_cov == CH_MAX) begin
            o_chan = i_fore;
        end else begin
            o_chan = w_fold[15:8];
        end
    end

endmodule

FILE: hdl/glyph_coverage_blend_writer_top.sv
// glyph_coverage_blend_writer_top: glyph pixel blend and framebuffer offset writer.
// Depends on gcbw_pkg and gcbw_blend.
// Each accepted item is registered in stage 1, then in stage 2; one item per cycle unless i_out_stall holds the output.
// Stage 1 holds pixel position and clip status, stage 2 the blend and the row-pitch multiply.
// Reset (synchronous, active low) clears counters and valids, and restores the
// screen registers to 1024 x 768 with a pitch of 4096 bytes.
`timescale 1ns / 1ps

module glyph_coverage_blend_writer_top import gcbw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [POS_W-1:0]      i_origin_x,
    input  logic [POS_W-1:0]      i_origin_y,
    input  logic [DIM_W-1:0]      i_glyph_width,
    input  logic [DIM_W-1:0]      i_glyph_height,
    input  logic [CH_W-1:0]       i_fore_red,
    input  logic [CH_W-1:0]       i_fore_green,
    input  logic [CH_W-1:0]       i_fore_blue,
    input  logic [CH_W-1:0]       i_back_red,
    input  logic [CH_W-1:0]       i_back_green,
    input  logic [CH_W-1:0]       i_back_blue,
    input  logic [CH_W-1:0]       i_coverage,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_write_enable,
    output logic [OFF_W-1:0]      o_byte_offset,
    output logic [3*CH_W-1:0]     o_pixel_word,
    output logic [1:0]            o_status
);

    localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

    // configuration
    logic [DIM_W-1:0]   r_scr_w;
    logic [DIM_W-1:0]   r_scr_h;
    logic [PITCH_W-1:0] r_pitch;

    // glyph counters
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;

    // stage 1
    logic               r_s1_v;
    logic [DIM_W-1:0]   r_px, n_px;
    logic [DIM_W-1:0]   r_py, n_py;
    logic [1:0]         r_s1_status, n_s1_status;
    logic [CH_W-1:0]    r_fr, r_fg, r_fb, r_br, r_bg, r_bb, r_cov;

    // stage 2
    logic               r_out_v;
    logic               r_out_we;
    logic [OFF_W-1:0]   r_out_off;
    logic [3*CH_W-1:0]  r_out_word;
    logic [1:0]         r_out_status;

    logic               w_out_ready;
    logic               w_s1_ready;
    logic               w_in_acc;
    logic [DIM_W-1:0]   w_gw, w_gh;
    logic [CH_W-1:0]    w_red, w_green, w_blue;
    logic [27:0]        w_prod;
    logic [OFF_W-1:0]   w_off;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > MaxDim) begin
            res = MaxDim;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign w_out_ready = !r_out_v || !i_out_stall;
    assign w_s1_ready  = !r_s1_v || w_out_ready;
    assign w_in_acc    = i_in_valid && w_s1_ready;
    assign o_in_stall  = !w_s1_ready;

    always_comb begin
        w_gw = clamp_dim(i_glyph_width);
        w_gh = clamp_dim(i_glyph_height);
        n_px = {1'b0, i_origin_x} + {1'b0, r_col};
        n_py = {1'b0, i_origin_y} + {1'b0, r_row};

        if (({1'b0, i_origin_x} >= r_scr_w) || ({1'b0, i_origin_y} >= r_scr_h)) begin
            n_s1_status = STATUS_ORIGIN_ERR;
        end else if ((n_px >= r_scr_w) || (n_py >= r_scr_h)) begin
            n_s1_status = STATUS_CLIPPED;
        end else begin
            n_s1_status = STATUS_WRITTEN;
        end

        n_col = r_col;
        n_row = r_row;
        if (({1'b0, r_col} + DIM_W'(1)) >= w_gw) begin
            n_col = '0;
            if (({1'b0, r_row} + DIM_W'(1)) >= w_gh) begin
                n_row = '0;
            end else begin
                n_row = r_row + POS_W'(1);
            end
        end else begin
            n_col = r_col + POS_W'(1);
        end
    end

    gcbw_blend u_blend_red (
        .i_fore (r_fr),
        .i_back (r_br),
        .i_cov  (r_cov),
        .o_chan (w_red)
    );

    gcbw_blend u_blend_green (
        .i_fore (r_fg),
        .i_back (r_bg),
        .i_cov  (r_cov),
        .o_chan (w_green)
    );

    gcbw_blend u_blend_blue (
        .i_fore (r_fb),
        .i_back (r_bb),
        .i_cov  (r_cov),
        .o_chan (w_blue)
    );

    always_comb begin
        w_prod = 28'(r_py) * 28'(r_pitch);
        w_off  = w_prod[OFF_W-1:0] + {11'd0, r_px, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= RST_SCREEN_W;
            r_scr_h <= RST_SCREEN_H;
            r_pitch <= RST_PITCH;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_wdata[DIM_W-1:0];
                CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_wdata[DIM_W-1:0];
                CFG_ROW_PITCH:     r_pitch <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_s1_ready) begin
                r_s1_v <= i_in_valid;
            end
            if (w_out_ready) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px        <= n_px;
            r_py        <= n_py;
            r_s1_status <= n_s1_status;
            r_fr        <= i_fore_red;
            r_fg        <= i_fore_green;
            r_fb        <= i_fore_blue;
            r_br        <= i_back_red;
            r_bg        <= i_back_green;
            r_bb        <= i_back_blue;
            r_cov       <= i_coverage;
        end
        if (w_out_ready && r_s1_v) begin
            r_out_status <= r_s1_status;
            if (r_s1_status == STATUS_WRITTEN) begin
                r_out_we   <= 1'b1;
                r_out_off  <= w_off;
                r_out_word <= {w_red, w_green, w_blue};
            end else begin
                r_out_we   <= 1'b0;
                r_out_off  <= '0;
                r_out_word <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_write_enable = r_out_we;
    assign o_byte_offset  = r_out_off;
    assign o_pixel_word   = r_out_word;
    assign o_status       = r_out_status;

endmodule
